### rtl/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg: shared types and constants for the binary min-heap
// Sizes, command and status codes, controller states, and the structs passed
// between the heap controller and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bmh_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 6;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 3;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // child index 2*i+2 must not wrap for the largest i
    localparam int CHILD_W  = ADDR_W + 2;

    localparam int IN_W        = CMD_W + KEY_W + POS_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = KEY_W + STAT_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W - 1){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_EXTRACT  = 2'd1,
        CMD_DECREASE = 2'd2,
        CMD_DELETE   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_FULL       = 3'd1,
        STAT_EMPTY      = 3'd2,
        STAT_BADPOS     = 3'd3,
        STAT_NOTSMALLER = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC_CHK,
        S_UP_RD,
        S_UP_CMP,
        S_TAKE,
        S_DN_LOAD,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_result;

    typedef struct packed {
        logic              wen;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_ram_req;

endpackage

`default_nettype wire

### rtl/bmh_ram.sv
// ----------------------------------------------------------------------------
// bmh_ram: heap key store
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wen,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr_a,
    input  wire logic [ADDR_W-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]  o_rdata_a,
    output logic      [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

### rtl/bmh_ctrl.sv
// ----------------------------------------------------------------------------
// bmh_ctrl: heap command sequencer
// Runs insert, extract, decrease and delete as read-compare-write steps on the
// key store, moving a hole up or down the tree with the moving key held here.
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire bmh_pkg::t_cmd               i_cmd,
    input  wire logic [bmh_pkg::KEY_W-1:0]   i_key,
    input  wire logic [bmh_pkg::POS_W-1:0]   i_pos,
    output bmh_pkg::t_ram_req                o_ram,
    input  wire logic [bmh_pkg::KEY_W-1:0]   i_rdata_a,
    input  wire logic [bmh_pkg::KEY_W-1:0]   i_rdata_b,
    input  wire logic                        i_slot_free,
    output logic                             o_done_valid,
    output bmh_pkg::t_result                 o_result
);

    localparam int ADDR_W  = bmh_pkg::ADDR_W;
    localparam int CNT_W   = bmh_pkg::CNT_W;
    localparam int CHILD_W = bmh_pkg::CHILD_W;
    localparam int KEY_W   = bmh_pkg::KEY_W;

    bmh_pkg::t_state  r_state,  n_state;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [ADDR_W-1:0] r_idx,   n_idx;
    logic [KEY_W-1:0] r_key,    n_key;
    logic [KEY_W-1:0] r_res,    n_res;
    logic             r_del,    n_del;
    logic             r_ext,    n_ext;
    bmh_pkg::t_status r_status, n_status;
    logic [KEY_W-1:0] r_root;

    logic [ADDR_W-1:0]  w_parent;
    logic [CHILD_W-1:0] w_lc;
    logic [CHILD_W-1:0] w_rc;
    logic               w_pos_ok;
    logic               w_take_l;
    logic               w_take_r;
    logic [KEY_W-1:0]   w_best_val;

    assign w_parent = (r_idx - ADDR_W'(1)) >> 1;
    assign w_lc     = (CHILD_W'(r_idx) << 1) + CHILD_W'(1);
    assign w_rc     = (CHILD_W'(r_idx) << 1) + CHILD_W'(2);
    assign w_pos_ok = CHILD_W'(i_pos) < CHILD_W'(r_count);

    // smaller child wins only when strictly below the moving key
    assign w_take_l   = (w_lc < CHILD_W'(r_count)) && ($signed(i_rdata_a) < $signed(r_key));
    assign w_best_val = w_take_l ? i_rdata_a : r_key;
    assign w_take_r   = (w_rc < CHILD_W'(r_count)) && ($signed(i_rdata_b) < $signed(w_best_val));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmh_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_res    <= n_res;
        r_del    <= n_del;
        r_ext    <= n_ext;
        r_status <= n_status;
        // shadow of the root entry
        if (o_ram.wen && (o_ram.waddr == '0)) begin
            r_root <= o_ram.wdata;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_key        = r_key;
        n_res        = r_res;
        n_del        = r_del;
        n_ext        = r_ext;
        n_status     = r_status;
        o_ram        = '0;
        o_in_ready   = 1'b0;
        o_done_valid = 1'b0;

        case (r_state)
            bmh_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_key    = i_key;
                    n_idx    = ADDR_W'(i_pos);
                    n_del    = 1'b0;
                    n_ext    = 1'b0;
                    n_status = bmh_pkg::STAT_OK;
                    case (i_cmd)
                        bmh_pkg::CMD_INSERT: begin
                            if (r_count == CNT_W'(bmh_pkg::CAPACITY)) begin
                                n_status = bmh_pkg::STAT_FULL;
                                n_state  = bmh_pkg::S_DONE;
                            end else begin
                                n_idx   = ADDR_W'(r_count);
                                n_count = r_count + CNT_W'(1);
                                n_state = bmh_pkg::S_UP_RD;
                            end
                        end
                        bmh_pkg::CMD_EXTRACT: begin
                            if (r_count == '0) begin
                                n_status = bmh_pkg::STAT_EMPTY;
                                n_state  = bmh_pkg::S_DONE;
                            end else begin
                                n_res   = r_root;
                                n_ext   = 1'b1;
                                n_state = bmh_pkg::S_TAKE;
                            end
                        end
                        bmh_pkg::CMD_DECREASE: begin
                            if (!w_pos_ok) begin
                                n_status = bmh_pkg::STAT_BADPOS;
                                n_state  = bmh_pkg::S_DONE;
                            end else begin
                                o_ram.raddr_a = ADDR_W'(i_pos);
                                n_state       = bmh_pkg::S_DEC_CHK;
                            end
                        end
                        bmh_pkg::CMD_DELETE: begin
                            if (!w_pos_ok) begin
                                n_status = bmh_pkg::STAT_BADPOS;
                                n_state  = bmh_pkg::S_DONE;
                            end else begin
                                n_key   = bmh_pkg::KEY_MIN;
                                n_del   = 1'b1;
                                n_state = bmh_pkg::S_UP_RD;
                            end
                        end
                        default: begin
                            n_state = bmh_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            bmh_pkg::S_DEC_CHK: begin
                if ($signed(r_key) > $signed(i_rdata_a)) begin
                    n_status = bmh_pkg::STAT_NOTSMALLER;
                    n_state  = bmh_pkg::S_DONE;
                end else begin
                    n_state = bmh_pkg::S_UP_RD;
                end
            end

            bmh_pkg::S_UP_RD: begin
                if (r_idx == '0) begin
                    o_ram.wen   = 1'b1;
                    o_ram.waddr = r_idx;
                    o_ram.wdata = r_key;
                    n_state     = r_del ? bmh_pkg::S_TAKE : bmh_pkg::S_DONE;
                end else begin
                    o_ram.raddr_a = w_parent;
                    n_state       = bmh_pkg::S_UP_CMP;
                end
            end

            bmh_pkg::S_UP_CMP: begin
                o_ram.wen   = 1'b1;
                o_ram.waddr = r_idx;
                if ($signed(i_rdata_a) > $signed(r_key)) begin
                    // parent moves down into the hole
                    o_ram.wdata = i_rdata_a;
                    n_idx       = w_parent;
                    n_state     = bmh_pkg::S_UP_RD;
                end else begin
                    o_ram.wdata = r_key;
                    n_state     = r_del ? bmh_pkg::S_TAKE : bmh_pkg::S_DONE;
                end
            end

            bmh_pkg::S_TAKE: begin
                n_count = r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) begin
                    n_state = bmh_pkg::S_DONE;
                end else begin
                    o_ram.raddr_a = ADDR_W'(r_count - CNT_W'(1));
                    n_state       = bmh_pkg::S_DN_LOAD;
                end
            end

            bmh_pkg::S_DN_LOAD: begin
                // last entry becomes the moving key, hole at the root
                n_key         = i_rdata_a;
                n_idx         = '0;
                o_ram.raddr_a = ADDR_W'(1);
                o_ram.raddr_b = ADDR_W'(2);
                n_state       = bmh_pkg::S_DN_CMP;
            end

            bmh_pkg::S_DN_RD: begin
                o_ram.raddr_a = ADDR_W'(w_lc);
                o_ram.raddr_b = ADDR_W'(w_rc);
                n_state       = bmh_pkg::S_DN_CMP;
            end

            bmh_pkg::S_DN_CMP: begin
                o_ram.wen   = 1'b1;
                o_ram.waddr = r_idx;
                if (w_take_r) begin
                    o_ram.wdata = i_rdata_b;
                    n_idx       = ADDR_W'(w_rc);
                    n_state     = bmh_pkg::S_DN_RD;
                end else if (w_take_l) begin
                    o_ram.wdata = i_rdata_a;
                    n_idx       = ADDR_W'(w_lc);
                    n_state     = bmh_pkg::S_DN_RD;
                end else begin
                    o_ram.wdata = r_key;
                    n_state     = bmh_pkg::S_DONE;
                end
            end

            bmh_pkg::S_DONE: begin
                o_done_valid = i_slot_free;
                if (i_slot_free) begin
                    n_state = bmh_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bmh_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.status = r_status;
        o_result.count  = r_count;
        if (r_ext) begin
            o_result.key = r_res;
        end else if (r_count != '0) begin
            o_result.key = r_root;
        end else begin
            o_result.key = '0;
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(bmh_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmh_pkg::S_IDLE || r_state == bmh_pkg::S_DONE) |-> !o_ram.wen)
        else $error("store written outside a command");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != bmh_pkg::S_IDLE))
        else $error("accepted transaction left no work");

    a_done_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done_valid |-> (i_slot_free && r_state == bmh_pkg::S_DONE))
        else $error("result issued without a free output slot");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.wen |-> (CNT_W'(o_ram.waddr) < r_count))
        else $error("store written beyond the entry count");

endmodule

`default_nettype wire

### rtl/binary_min_heap.sv
// ----------------------------------------------------------------------------
// binary_min_heap: min-heap priority queue of signed 32-bit keys
// Heap of up to 64 keys held in a synchronous RAM, one command per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction: insert, extract minimum,
//   decrease key at a position, or delete at a position. m_axis returns one
//   result per command: key, status and the entry count after the command.
//   Commands are worked one at a time. Each tree level is a registered
//   RAM read, then a compare and write back. At 64 entries a key moves up
//   to 6 levels up and 5 down; a delete walks up and then down. A decrease
//   to a larger key is rejected after the stored key is read. After a
//   command the sequencer returns to idle before it takes the next one.
//   s_axis_tready is high whenever the sequencer is idle, so a new command
//   is taken while the previous result still waits in the output register.
//   If m_axis is stalled, the finished command holds until the register
//   drains. Reset empties the heap at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // command[1:0], key_value[33:2], position[39:34]
    input  wire logic [bmh_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // result_key[31:0], status[34:32], entry_count[41:35], zero padding above
    output logic      [bmh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int CMD_W = bmh_pkg::CMD_W;
    localparam int KEY_W = bmh_pkg::KEY_W;
    localparam int POS_W = bmh_pkg::POS_W;

    bmh_pkg::t_cmd          w_cmd;
    logic [KEY_W-1:0]       w_key;
    logic [POS_W-1:0]       w_pos;
    bmh_pkg::t_ram_req      w_ram;
    logic [KEY_W-1:0]       w_rdata_a;
    logic [KEY_W-1:0]       w_rdata_b;
    logic                   w_slot_free;
    logic                   w_done_valid;
    bmh_pkg::t_result       w_result;

    logic                   r_m_valid;
    bmh_pkg::t_result       r_m_result;

    assign w_cmd = bmh_pkg::t_cmd'(s_axis_tdata[CMD_W-1:0]);
    assign w_key = s_axis_tdata[CMD_W +: KEY_W];
    assign w_pos = s_axis_tdata[CMD_W + KEY_W +: POS_W];

    assign w_slot_free = !r_m_valid || m_axis_tready;

    bmh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_cmd        (w_cmd),
        .i_key        (w_key),
        .i_pos        (w_pos),
        .o_ram        (w_ram),
        .i_rdata_a    (w_rdata_a),
        .i_rdata_b    (w_rdata_b),
        .i_slot_free  (w_slot_free),
        .o_done_valid (w_done_valid),
        .o_result     (w_result)
    );

    bmh_ram #(
        .DEPTH  (bmh_pkg::CAPACITY),
        .WIDTH  (KEY_W),
        .ADDR_W (bmh_pkg::ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wen     (w_ram.wen),
        .i_waddr   (w_ram.waddr),
        .i_wdata   (w_ram.wdata),
        .i_raddr_a (w_ram.raddr_a),
        .i_raddr_b (w_ram.raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_done_valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done_valid) begin
            r_m_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = bmh_pkg::OUT_TDATA_W'({r_m_result.count,
                                                  r_m_result.status,
                                                  r_m_result.key});

endmodule

`default_nettype wire
